/* design/hmt_pkg.sv */
package hmt_pkg;

   localparam int CHAR_WIDTH_DEFAULT = 21;
   localparam int KIND_WIDTH         = 5;
   localparam int TOKEN_SLOTS        = 3;
   localparam int COUNT_WIDTH        = 2;

   // token kinds
   localparam logic [KIND_WIDTH-1:0] KIND_NEWLINE    = 5'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_SETTING    = 5'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_ENDTAG     = 5'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_LATIN      = 5'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_BOLD       = 5'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_ITALIC     = 5'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_TRANSLIT   = 5'd6;
   localparam logic [KIND_WIDTH-1:0] KIND_SEPARATOR  = 5'd7;
   localparam logic [KIND_WIDTH-1:0] KIND_VGROUP     = 5'd8;
   localparam logic [KIND_WIDTH-1:0] KIND_HGROUP     = 5'd9;
   localparam logic [KIND_WIDTH-1:0] KIND_OPEN       = 5'd10;
   localparam logic [KIND_WIDTH-1:0] KIND_CLOSE      = 5'd11;
   localparam logic [KIND_WIDTH-1:0] KIND_LINEEND    = 5'd12;
   localparam logic [KIND_WIDTH-1:0] KIND_TEXT       = 5'd13;
   localparam logic [KIND_WIDTH-1:0] KIND_CART_OPEN  = 5'd14;
   localparam logic [KIND_WIDTH-1:0] KIND_CART_CLOSE = 5'd15;
   localparam logic [KIND_WIDTH-1:0] KIND_FULL_SPACE = 5'd16;
   localparam logic [KIND_WIDTH-1:0] KIND_HALF_SPACE = 5'd17;
   localparam logic [KIND_WIDTH-1:0] KIND_ERROR      = 5'd18;

   // markup characters
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_BANG      = 8'h21;
   localparam logic [7:0] CH_LESS      = 8'h3C;
   localparam logic [7:0] CH_GREATER   = 8'h3E;
   localparam logic [7:0] CH_LOWER_S   = 8'h73;
   localparam logic [7:0] CH_LOWER_L   = 8'h6C;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_I   = 8'h69;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;

   typedef enum logic [7:0] {
      MODE_START  = 8'b0000_0001,
      MODE_IDLE   = 8'b0000_0010,
      MODE_NL     = 8'b0000_0100,
      MODE_NLPLUS = 8'b0000_1000,
      MODE_PLUS   = 8'b0001_0000,
      MODE_BSL    = 8'b0010_0000,
      MODE_DOT    = 8'b0100_0000,
      MODE_DROP   = 8'b1000_0000
   } mode_type;

endpackage

/* design/hieroglyph_markup_tokenizer.sv */
// Markup tokenizer for hieroglyphic text.
// Request channel (req_*): one character per item in req_tdata; req_tlast marks
// the final character of a text. Response channel (rsp_*): one token per item,
// kind in rsp_tuser, character (text or offending tag) in rsp_tdata, rsp_tlast
// on the final token caused by one request item. An item may cause no token.
// Every text opens with an implicit newline token; one or two characters of
// lookahead are held in the pending mode register between items.
// The first token of an item is presented the cycle after it is accepted.
// Throughput, while rsp_tready is high: one item per cycle when each item
// gives at most one token; an item of N tokens (N up to 2) holds the response
// register while they leave, one per cycle, through a 3-slot result buffer.
// The next item is accepted in the same cycle the last buffered token leaves.
// Stall: when rsp_tready is low the buffered tokens hold and req_tready drops
// once the buffer is not about to drain; nothing is lost or repeated.
// Reset (synchronous, active high): buffer emptied, pending mode returns to
// start of text.
module hieroglyph_markup_tokenizer #(
   parameter int CHAR_WIDTH = hmt_pkg::CHAR_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [((CHAR_WIDTH + 7) / 8) * 8 - 1:0] req_tdata, // [CHAR_WIDTH-1:0] character
   input  logic                   req_tlast,   // end_of_text

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [((CHAR_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata, // [CHAR_WIDTH-1:0] text_char
   output logic [hmt_pkg::KIND_WIDTH-1:0] rsp_tuser, // [4:0] token_kind
   output logic                   rsp_tlast    // last_of_run
);

   localparam int REQ_DATA_W = ((CHAR_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CHAR_WIDTH + 7) / 8) * 8;

   hmt_pkg::mode_type                     mode_ff;
   hmt_pkg::mode_type                     mode_in;

   // result buffer: remaining tokens and read position
   logic [hmt_pkg::COUNT_WIDTH-1:0]       rem_ff, rem_in;
   logic [hmt_pkg::COUNT_WIDTH-1:0]       pos_ff, pos_in;
   logic [hmt_pkg::KIND_WIDTH-1:0]        kind_ff [hmt_pkg::TOKEN_SLOTS];
   logic [CHAR_WIDTH-1:0]                 chr_ff  [hmt_pkg::TOKEN_SLOTS];

   logic [hmt_pkg::COUNT_WIDTH-1:0]       dec_count;
   logic [hmt_pkg::KIND_WIDTH-1:0]        dec_kind [hmt_pkg::TOKEN_SLOTS];
   logic [CHAR_WIDTH-1:0]                 dec_chr  [hmt_pkg::TOKEN_SLOTS];

   logic                                  req_take;
   logic                                  rsp_take;

   hmt_decode #(
      .CHAR_WIDTH (CHAR_WIDTH)
   ) u_decode (
      .mode      (mode_ff),
      .chr       (req_tdata[CHAR_WIDTH-1:0]),
      .last      (req_tlast),
      .next_mode (mode_in),
      .tok_count (dec_count),
      .tok_kind  (dec_kind),
      .tok_chr   (dec_chr)
   );

   assign rsp_tvalid = (rem_ff != '0);
   assign rsp_tlast  = (rem_ff == hmt_pkg::COUNT_WIDTH'(1));
   assign rsp_take   = rsp_tvalid && rsp_tready;
   // take a new item once the buffer is empty or its final token leaves now
   assign req_tready = (rem_ff == '0) || (rsp_tlast && rsp_tready);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      unique case (pos_ff)
         hmt_pkg::COUNT_WIDTH'(1): begin
            rsp_tuser = kind_ff[1];
            rsp_tdata = RSP_DATA_W'(chr_ff[1]);
         end
         hmt_pkg::COUNT_WIDTH'(2): begin
            rsp_tuser = kind_ff[2];
            rsp_tdata = RSP_DATA_W'(chr_ff[2]);
         end
         default: begin
            rsp_tuser = kind_ff[0];
            rsp_tdata = RSP_DATA_W'(chr_ff[0]);
         end
      endcase
   end

   always_comb begin
      rem_in = rem_ff;
      pos_in = pos_ff;
      if (req_take) begin
         rem_in = dec_count;
         pos_in = '0;
      end else if (rsp_take) begin
         rem_in = rem_ff - hmt_pkg::COUNT_WIDTH'(1);
         pos_in = pos_ff + hmt_pkg::COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hmt_pkg::MODE_START;
         rem_ff  <= '0;
         pos_ff  <= '0;
      end else begin
         rem_ff <= rem_in;
         pos_ff <= pos_in;
         if (req_take) begin
            mode_ff <= mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= dec_kind;
         chr_ff  <= dec_chr;
      end
   end

endmodule

/* design/hmt_decode.sv */
module hmt_decode #(
   parameter int CHAR_WIDTH = hmt_pkg::CHAR_WIDTH_DEFAULT
) (
   input  hmt_pkg::mode_type                     mode,
   input  logic [CHAR_WIDTH-1:0]                 chr,
   input  logic                                  last,
   output hmt_pkg::mode_type                     next_mode,
   output logic [hmt_pkg::COUNT_WIDTH-1:0]       tok_count,
   output logic [hmt_pkg::KIND_WIDTH-1:0]        tok_kind [hmt_pkg::TOKEN_SLOTS],
   output logic [CHAR_WIDTH-1:0]                 tok_chr  [hmt_pkg::TOKEN_SLOTS]
);

   localparam logic [CHAR_WIDTH-1:0] C_NEWLINE   = CHAR_WIDTH'(hmt_pkg::CH_NEWLINE);
   localparam logic [CHAR_WIDTH-1:0] C_PLUS      = CHAR_WIDTH'(hmt_pkg::CH_PLUS);
   localparam logic [CHAR_WIDTH-1:0] C_BACKSLASH = CHAR_WIDTH'(hmt_pkg::CH_BACKSLASH);
   localparam logic [CHAR_WIDTH-1:0] C_DOT       = CHAR_WIDTH'(hmt_pkg::CH_DOT);
   localparam logic [CHAR_WIDTH-1:0] C_MINUS     = CHAR_WIDTH'(hmt_pkg::CH_MINUS);
   localparam logic [CHAR_WIDTH-1:0] C_COLON     = CHAR_WIDTH'(hmt_pkg::CH_COLON);
   localparam logic [CHAR_WIDTH-1:0] C_STAR      = CHAR_WIDTH'(hmt_pkg::CH_STAR);
   localparam logic [CHAR_WIDTH-1:0] C_LPAREN    = CHAR_WIDTH'(hmt_pkg::CH_LPAREN);
   localparam logic [CHAR_WIDTH-1:0] C_RPAREN    = CHAR_WIDTH'(hmt_pkg::CH_RPAREN);
   localparam logic [CHAR_WIDTH-1:0] C_BANG      = CHAR_WIDTH'(hmt_pkg::CH_BANG);
   localparam logic [CHAR_WIDTH-1:0] C_LESS      = CHAR_WIDTH'(hmt_pkg::CH_LESS);
   localparam logic [CHAR_WIDTH-1:0] C_GREATER   = CHAR_WIDTH'(hmt_pkg::CH_GREATER);
   localparam logic [CHAR_WIDTH-1:0] C_LOWER_S   = CHAR_WIDTH'(hmt_pkg::CH_LOWER_S);
   localparam logic [CHAR_WIDTH-1:0] C_LOWER_L   = CHAR_WIDTH'(hmt_pkg::CH_LOWER_L);
   localparam logic [CHAR_WIDTH-1:0] C_LOWER_B   = CHAR_WIDTH'(hmt_pkg::CH_LOWER_B);
   localparam logic [CHAR_WIDTH-1:0] C_LOWER_I   = CHAR_WIDTH'(hmt_pkg::CH_LOWER_I);
   localparam logic [CHAR_WIDTH-1:0] C_LOWER_T   = CHAR_WIDTH'(hmt_pkg::CH_LOWER_T);

   // no-lookahead handling of the character
   logic                             plain_v;
   logic [hmt_pkg::KIND_WIDTH-1:0]   plain_k;
   logic [CHAR_WIDTH-1:0]            plain_c;
   hmt_pkg::mode_type                plain_mode;

   // tag character after '+'
   logic [hmt_pkg::KIND_WIDTH-1:0]   tag_k;
   hmt_pkg::mode_type                tag_mode;

   // lead, body and tail token candidates, emitted in that order
   logic                             lead_v, body_v, tail_v;
   logic [hmt_pkg::KIND_WIDTH-1:0]   lead_k, body_k, tail_k;
   logic [CHAR_WIDTH-1:0]            lead_c, body_c, tail_c;
   hmt_pkg::mode_type                mid_mode;

   always_comb begin
      plain_v    = 1'b1;
      plain_c    = '0;
      plain_k    = hmt_pkg::KIND_TEXT;
      plain_mode = hmt_pkg::MODE_IDLE;
      unique case (chr)
         C_NEWLINE: begin
            plain_k    = hmt_pkg::KIND_NEWLINE;
            plain_mode = hmt_pkg::MODE_NL;
         end
         C_PLUS: begin
            plain_v    = 1'b0;
            plain_mode = hmt_pkg::MODE_PLUS;
         end
         C_BACKSLASH: begin
            plain_v    = 1'b0;
            plain_mode = hmt_pkg::MODE_BSL;
         end
         C_DOT: begin
            plain_v    = 1'b0;
            plain_mode = hmt_pkg::MODE_DOT;
         end
         C_MINUS:   plain_k = hmt_pkg::KIND_SEPARATOR;
         C_COLON:   plain_k = hmt_pkg::KIND_VGROUP;
         C_STAR:    plain_k = hmt_pkg::KIND_HGROUP;
         C_LPAREN:  plain_k = hmt_pkg::KIND_OPEN;
         C_RPAREN:  plain_k = hmt_pkg::KIND_CLOSE;
         C_BANG:    plain_k = hmt_pkg::KIND_LINEEND;
         C_LESS:    plain_k = hmt_pkg::KIND_CART_OPEN;
         C_GREATER: plain_k = hmt_pkg::KIND_CART_CLOSE;
         default:   plain_c = chr;
      endcase
   end

   always_comb begin
      tag_mode = hmt_pkg::MODE_IDLE;
      unique case (chr)
         C_LOWER_S: tag_k = hmt_pkg::KIND_ENDTAG;
         C_LOWER_L: tag_k = hmt_pkg::KIND_LATIN;
         C_LOWER_B: tag_k = hmt_pkg::KIND_BOLD;
         C_LOWER_I: tag_k = hmt_pkg::KIND_ITALIC;
         C_LOWER_T: tag_k = hmt_pkg::KIND_TRANSLIT;
         default: begin
            tag_k    = hmt_pkg::KIND_ERROR;
            tag_mode = hmt_pkg::MODE_DROP;
         end
      endcase
   end

   always_comb begin
      lead_v   = 1'b0;
      lead_k   = hmt_pkg::KIND_NEWLINE;
      lead_c   = '0;
      body_v   = plain_v;
      body_k   = plain_k;
      body_c   = plain_c;
      mid_mode = plain_mode;
      unique case (mode)
         hmt_pkg::MODE_START, hmt_pkg::MODE_NL: begin
            lead_v = (mode == hmt_pkg::MODE_START);
            if (chr == C_PLUS) begin
               body_v   = 1'b0;
               mid_mode = hmt_pkg::MODE_NLPLUS;
            end
         end
         hmt_pkg::MODE_NLPLUS: begin
            if (chr == C_PLUS) begin
               body_k   = hmt_pkg::KIND_SETTING;
               body_c   = '0;
               mid_mode = hmt_pkg::MODE_IDLE;
            end else begin
               body_k   = tag_k;
               body_c   = (tag_k == hmt_pkg::KIND_ERROR) ? chr : '0;
               mid_mode = tag_mode;
            end
            body_v = 1'b1;
         end
         hmt_pkg::MODE_PLUS: begin
            body_v   = 1'b1;
            body_k   = tag_k;
            body_c   = (tag_k == hmt_pkg::KIND_ERROR) ? chr : '0;
            mid_mode = tag_mode;
         end
         hmt_pkg::MODE_BSL: begin
            if (chr == C_PLUS) begin
               body_v   = 1'b1;
               body_k   = hmt_pkg::KIND_TEXT;
               body_c   = C_PLUS;
               mid_mode = hmt_pkg::MODE_IDLE;
            end else begin
               lead_v = 1'b1;
               lead_k = hmt_pkg::KIND_TEXT;
               lead_c = C_BACKSLASH;
            end
         end
         hmt_pkg::MODE_DOT: begin
            if (chr == C_DOT) begin
               body_v   = 1'b1;
               body_k   = hmt_pkg::KIND_FULL_SPACE;
               body_c   = '0;
               mid_mode = hmt_pkg::MODE_IDLE;
            end else begin
               lead_v = 1'b1;
               lead_k = hmt_pkg::KIND_HALF_SPACE;
            end
         end
         hmt_pkg::MODE_DROP: begin
            body_v   = 1'b0;
            mid_mode = hmt_pkg::MODE_DROP;
         end
         default: ;
      endcase
   end

   // flush of pending lookahead at the end of a text
   always_comb begin
      tail_v = 1'b0;
      tail_k = hmt_pkg::KIND_ERROR;
      tail_c = '0;
      if (last) begin
         unique case (mid_mode)
            hmt_pkg::MODE_NLPLUS, hmt_pkg::MODE_PLUS: tail_v = 1'b1;
            hmt_pkg::MODE_BSL: begin
               tail_v = 1'b1;
               tail_k = hmt_pkg::KIND_TEXT;
               tail_c = C_BACKSLASH;
            end
            hmt_pkg::MODE_DOT: begin
               tail_v = 1'b1;
               tail_k = hmt_pkg::KIND_HALF_SPACE;
            end
            default: ;
         endcase
      end
      next_mode = last ? hmt_pkg::MODE_START : mid_mode;
   end

   // pack valid candidates into the low slots
   always_comb begin
      tok_count = hmt_pkg::COUNT_WIDTH'(lead_v) + hmt_pkg::COUNT_WIDTH'(body_v)
                + hmt_pkg::COUNT_WIDTH'(tail_v);
      if (lead_v) begin
         tok_kind[0] = lead_k;
         tok_chr[0]  = lead_c;
      end else if (body_v) begin
         tok_kind[0] = body_k;
         tok_chr[0]  = body_c;
      end else begin
         tok_kind[0] = tail_k;
         tok_chr[0]  = tail_c;
      end
      if (lead_v && body_v) begin
         tok_kind[1] = body_k;
         tok_chr[1]  = body_c;
      end else begin
         tok_kind[1] = tail_k;
         tok_chr[1]  = tail_c;
      end
      tok_kind[2] = tail_k;
      tok_chr[2]  = tail_c;
   end

endmodule
